// ----- design/gre_pkg.sv -----
`timescale 1ns / 1ps

package gre_pkg;

  // Sizing
  localparam int MAX_NODES = 32;
  localparam int ROWS      = 32;
  localparam int ROW_W     = 32;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int NODE_W    = 6;
  localparam int CMD_W     = 2;
  localparam int ACTIVE_CAP = (MAX_NODES < ROWS) ? MAX_NODES : ROWS;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PATH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } gre_state_t;

  // Walk request from sequencer to traversal unit
  typedef struct packed {
    logic              start;
    logic [ROW_AW-1:0] node;
    logic [ROWS-1:0]   mask;
  } walk_req_t;

  // Walk status back to sequencer
  typedef struct packed {
    logic            done;
    logic            all_reached;
    logic [ROWS-1:0] visited;
  } walk_rsp_t;

endpackage

// ----- design/gre_ram.sv -----
`timescale 1ns / 1ps

module gre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/gre_walk.sv -----
`timescale 1ns / 1ps

module gre_walk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gre_pkg::walk_req_t        req,
  output gre_pkg::walk_rsp_t        rsp,
  output logic                      rd_en,
  output logic [gre_pkg::ROW_AW-1:0] rd_addr,
  input  logic [gre_pkg::ROW_W-1:0] rd_data
);
  import gre_pkg::*;

  logic              active_r;
  logic              inflight_r;
  logic [ROWS-1:0]   visited_r;
  logic [ROWS-1:0]   pending_r;
  logic [ROWS-1:0]   mask_r;
  logic [ROWS-1:0]   low_bit;
  logic [ROWS-1:0]   new_bits;
  logic [ROW_AW-1:0] pick;
  logic              finished;

  // Pick the lowest pending node; its row is read this cycle
  always_comb begin
    low_bit = pending_r & (~pending_r + ROWS'(1));
    pick    = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (low_bit[i]) begin
        pick = pick | ROW_AW'(i);
      end
    end
  end

  // Row returned from last cycle's read: keep only unseen active nodes
  assign new_bits = inflight_r ? (rd_data[ROWS-1:0] & mask_r & ~visited_r) : '0;
  assign finished = active_r && !inflight_r && (pending_r == '0);

  assign rd_en   = active_r && (pending_r != '0);
  assign rd_addr = pick;

  assign rsp.done        = finished;
  assign rsp.all_reached = (visited_r == mask_r);
  assign rsp.visited     = visited_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      inflight_r <= 1'b0;
    end else if (req.start) begin
      active_r   <= 1'b1;
      inflight_r <= 1'b0;
    end else if (active_r) begin
      inflight_r <= rd_en;
      if (finished) begin
        active_r <= 1'b0;
      end
    end
  end

  // Reached and to-expand sets
  always_ff @(posedge clk) begin
    if (req.start) begin
      visited_r <= ROWS'(1) << req.node;
      pending_r <= ROWS'(1) << req.node;
      mask_r    <= req.mask;
    end else if (active_r) begin
      visited_r <= visited_r | new_bits;
      pending_r <= (pending_r & ~low_bit) | new_bits;
    end
  end

endmodule

// ----- design/graph_reachability_engine.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                         Handshake
// request   start, in_cmd, in_row_index, in_row_bits,     start && !busy
//           in_source_node, in_target_node
// result    out_valid, out_answer, out_done_cmd           out_valid, one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_data                cfg_valid && cfg_ready
//
// Loads and queries with a trivial answer return their result the cycle after the
// request; busy stays low. A walking query reads each reached node's row once through
// one shared read port of the adjacency RAM, plus a bubble with no read whenever the row in
// flight is the only source of new nodes; busy stays high for the whole walk, and the
// result shows in the cycle busy drops. cmd 3 is dropped.
// Synchronous reset clears the adjacency row valid bits (all rows read as zero),
// node_count and the sequencer. The result side cannot stall.

module graph_reachability_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [gre_pkg::CMD_W-1:0]   in_cmd,
  input  logic [gre_pkg::ROW_AW-1:0]  in_row_index,
  input  logic [gre_pkg::ROW_W-1:0]   in_row_bits,
  input  logic [gre_pkg::NODE_W-1:0]  in_source_node,
  input  logic [gre_pkg::NODE_W-1:0]  in_target_node,
  output logic                        out_valid,
  output logic                        out_answer,
  output logic [gre_pkg::CMD_W-1:0]   out_done_cmd,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gre_pkg::NODE_W-1:0]  cfg_data
);
  import gre_pkg::*;

  gre_state_t        state_r, state_nxt;
  logic [NODE_W-1:0] node_count_r;
  logic [ROWS-1:0]   row_valid_r;
  logic              row_ok_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_answer_r, out_answer_nxt;
  logic [CMD_W-1:0]  out_cmd_r, out_cmd_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [ROW_AW-1:0] dst_r;

  logic              accept;
  logic [NODE_W-1:0] n_act;
  logic [ROWS-1:0]   mask;
  logic              src_ok, dst_ok, load_ok;
  logic              ram_we;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_data;
  walk_req_t         wreq;
  walk_rsp_t         wrsp;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Active node count and column mask
  always_comb begin
    n_act = (node_count_r > NODE_W'(ACTIVE_CAP)) ? NODE_W'(ACTIVE_CAP) : node_count_r;
    for (int i = 0; i < ROWS; i++) begin
      mask[i] = (NODE_W'(i) < n_act);
    end
  end

  assign src_ok  = (in_source_node < n_act);
  assign dst_ok  = (in_target_node < n_act);
  assign load_ok = (NODE_W'(in_row_index) < NODE_W'(ACTIVE_CAP));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_cmd == CMD_CONN) && (n_act != '0)) begin
            state_nxt = ST_WALK;
          end else if ((in_cmd == CMD_PATH) && src_ok && dst_ok &&
                       (in_source_node != in_target_node)) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (wrsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: result strobe, RAM write, walk launch
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_answer_nxt = 1'b0;
    out_cmd_nxt    = out_cmd_r;
    ram_we         = 1'b0;
    wreq.start     = 1'b0;
    wreq.node      = '0;
    wreq.mask      = mask;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_cmd_nxt = in_cmd;
          case (in_cmd)
            CMD_LOAD: begin
              ram_we        = load_ok;
              out_valid_nxt = 1'b1;
            end
            CMD_CONN: begin
              if (n_act == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                wreq.start = 1'b1;
              end
            end
            CMD_PATH: begin
              if (!(src_ok && dst_ok)) begin
                out_valid_nxt = 1'b1;
              end else if (in_source_node == in_target_node) begin
                out_valid_nxt  = 1'b1;
                out_answer_nxt = 1'b1;
              end else begin
                wreq.start = 1'b1;
                wreq.node  = in_source_node[ROW_AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (wrsp.done) begin
          out_valid_nxt  = 1'b1;
          out_cmd_nxt    = cmd_r;
          out_answer_nxt = (cmd_r == CMD_CONN) ? wrsp.all_reached : wrsp.visited[dst_r];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= '0;
      row_valid_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
      if (ram_we) begin
        row_valid_r[in_row_index] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_answer_r <= out_answer_nxt;
    out_cmd_r    <= out_cmd_nxt;
    if (wreq.start) begin
      cmd_r <= in_cmd;
      dst_r <= in_target_node[ROW_AW-1:0];
    end
    if (rd_en) begin
      row_ok_r <= row_valid_r[rd_addr];
    end
  end

  // Rows never loaded since reset read as zero
  assign row_data = ram_rdata & {ROW_W{row_ok_r}};

  gre_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_adj_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_row_index),
    .wdata(in_row_bits),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  gre_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (wreq),
    .rsp    (wrsp),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(row_data)
  );

  assign out_valid    = out_valid_r;
  assign out_answer   = out_answer_r;
  assign out_done_cmd = out_cmd_r;

endmodule

// ----- design/gre_checker.sv -----
`timescale 1ns / 1ps

module gre_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [gre_pkg::CMD_W-1:0]  in_cmd,
  input logic                       out_valid,
  input logic                       out_answer,
  input logic [gre_pkg::CMD_W-1:0]  out_done_cmd
);
  import gre_pkg::*;

  // No result is shown while a walk is running
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_valid))
    else $error("result strobe while busy");

  // A finished walk always reports in the cycle busy drops
  a_walk_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("walk ended without a result");

  // A load request answers on the next cycle with answer low
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_LOAD)) |=>
      (out_valid && (out_done_cmd == CMD_LOAD) && !out_answer))
    else $error("load request not answered");

  // Dropped command code never shows on the result side
  a_no_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done_cmd != CMD_NONE))
    else $error("result for undefined command");

endmodule

bind graph_reachability_engine gre_checker u_gre_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_cmd      (in_cmd),
  .out_valid   (out_valid),
  .out_answer  (out_answer),
  .out_done_cmd(out_done_cmd)
);

// ----- tb/graph_reachability_engine_test.sv -----
`timescale 1ns / 1ps

module graph_reachability_engine_test;
  import gre_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS   = 20_000_000;

  typedef struct packed {
    logic             answer;
    logic [CMD_W-1:0] cmd;
  } reach_result_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd         = CMD_LOAD;
  logic [ROW_AW-1:0]   in_row_index   = '0;
  logic [ROW_W-1:0]    in_row_bits    = '0;
  logic [NODE_W-1:0]   in_source_node = '0;
  logic [NODE_W-1:0]   in_target_node = '0;
  logic                out_valid;
  logic                out_answer;
  logic [CMD_W-1:0]    out_done_cmd;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [NODE_W-1:0]   cfg_data       = '0;

  // Shadow copy of the engine state
  logic [ROW_W-1:0]    adj_model [ROWS];
  logic [NODE_W-1:0]   node_count_model;
  reach_result_t       pending_results [$];

  int sender_idle_pct = 0;
  int fail_count      = 0;
  int items_sent      = 0;
  int load_count      = 0;
  int conn_count      = 0;
  int path_count      = 0;
  int dropped_count   = 0;
  int results_checked = 0;
  int cfg_writes      = 0;

  graph_reachability_engine u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_row_index   (in_row_index),
    .in_row_bits    (in_row_bits),
    .in_source_node (in_source_node),
    .in_target_node (in_target_node),
    .out_valid      (out_valid),
    .out_answer     (out_answer),
    .out_done_cmd   (out_done_cmd),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Level-by-level expansion; returns the set of nodes reached from origin
  function automatic logic [ROWS-1:0] walk_reach(input logic [ROW_AW-1:0] origin,
                                                 input logic [ROWS-1:0] mask);
    logic [ROWS-1:0] seen;
    logic [ROWS-1:0] front;
    logic [ROWS-1:0] nxt;
    seen  = '0;
    seen[origin] = 1'b1;
    front = seen;
    while (front != '0) begin
      nxt = '0;
      for (int i = 0; i < ROWS; i++) begin
        if (front[i]) nxt |= adj_model[i] & mask;
      end
      front = nxt & ~seen;
      seen |= front;
    end
    return seen;
  endfunction

  // Edge row generator; mode picks the graph flavor
  function automatic logic [ROW_W-1:0] make_row_bits(input int mode, input int node,
                                                     input int rows);
    logic [ROW_W-1:0] bits;
    case (mode)
      0: bits = $urandom;
      1: bits = $urandom & $urandom & $urandom;
      2: begin
        // ring through the active nodes, occasionally broken, with stray extras
        bits = ROW_W'(1) << ((node + 1) % rows);
        if ($urandom_range(3) == 0) bits |= ROW_W'(1) << $urandom_range(31);
        if ($urandom_range(7) == 0) bits = '0;
      end
      default: bits = (ROW_W'(1) << $urandom_range(31)) | (ROW_W'(1) << $urandom_range(31));
    endcase
    return bits;
  endfunction

  // Issue one request, wait for acceptance, then queue the predicted result
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ROW_AW-1:0] row,
                           input logic [ROW_W-1:0] bits, input logic [NODE_W-1:0] src,
                           input logic [NODE_W-1:0] dst);
    int            gap;
    int            n;
    logic [ROWS-1:0] mask;
    logic [ROWS-1:0] seen;
    reach_result_t res;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_row_index   <= row;
    in_row_bits    <= bits;
    in_source_node <= src;
    in_target_node <= dst;
    do @(posedge clk); while (busy);

    n    = (node_count_model < ACTIVE_CAP) ? int'(node_count_model) : ACTIVE_CAP;
    mask = (n >= ROWS) ? '1 : ((ROWS'(1) << n) - 1);
    res.answer = 1'b0;
    res.cmd    = cmd;
    case (cmd)
      CMD_LOAD: begin
        if (row < ACTIVE_CAP) adj_model[row] = bits;
        load_count++;
      end
      CMD_CONN: begin
        if (n != 0) begin
          seen = walk_reach('0, mask);
          res.answer = (seen == mask);
        end
        conn_count++;
      end
      CMD_PATH: begin
        if (src < n && dst < n) begin
          if (src == dst) begin
            res.answer = 1'b1;
          end else begin
            seen = walk_reach(src[ROW_AW-1:0], mask);
            res.answer = seen[dst[ROW_AW-1:0]];
          end
        end
        path_count++;
      end
      default: dropped_count++;
    endcase
    if (cmd != CMD_NONE) begin
      pending_results.push_back(res);
      items_sent++;
    end
  endtask

  // Register write, only once the engine has gone quiet
  task automatic write_node_count(input logic [NODE_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    node_count_model = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every strobe is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    reach_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: answer %0d done_cmd %0d",
               out_answer, out_done_cmd);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_answer !== exp_r.answer) begin
          $error("answer: expected %0d, got %0d", exp_r.answer, out_answer);
          fail_count++;
        end
        if (out_done_cmd !== exp_r.cmd) begin
          $error("done_cmd: expected %0d, got %0d", exp_r.cmd, out_done_cmd);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  // Zero nodes after reset, then two nodes with unloaded rows: every query is false, rows read as zero
  task automatic test_after_reset();
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_LOAD, 5'd31, 32'hFFFF_FFFF, 6'd0, 6'd0);
    write_node_count(6'd2);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd0, 6'd1);
  endtask

  // Field extremes, saturation of the node count, ignored columns, dropped command
  task automatic test_directed_cases();
    write_node_count(6'd32);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd31, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd63, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd0, 6'd32);
    send_item(CMD_LOAD, 5'd0, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_NONE, 5'd31, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_item(CMD_LOAD, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    write_node_count(6'd1);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd0, 6'd1);
    write_node_count(6'd63);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd31, 6'd5);
    send_item(CMD_LOAD, 5'd0, 32'h8000_0000, 6'd0, 6'd0);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    write_node_count(6'd2);
    send_item(CMD_LOAD, 5'd0, 32'hFFFF_FFFC, 6'd0, 6'd0);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
    send_item(CMD_PATH, 5'd0, 32'h0, 6'd0, 6'd1);
    send_item(CMD_LOAD, 5'd0, 32'h0000_0002, 6'd0, 6'd0);
    send_item(CMD_CONN, 5'd0, 32'h0, 6'd0, 6'd0);
  endtask

  // Random graphs: load a whole graph, then a burst of queries with some noise
  task automatic test_random_graphs(input int quota, input int idle_pct);
    int base;
    int r;
    int n;
    int rows;
    int mode;
    int queries;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    base = items_sent;
    sender_idle_pct = idle_pct;
    while (items_sent - base < quota) begin
      r = $urandom_range(99);
      if (r < 5)       n = 0;
      else if (r < 10) n = 32;
      else if (r < 14) n = $urandom_range(63, 33);
      else if (r < 40) n = $urandom_range(9, 1);
      else             n = $urandom_range(31, 2);
      write_node_count(NODE_W'(n));
      rows = (n > ROWS) ? ROWS : n;
      mode = $urandom_range(3);

      for (int i = 0; i < rows; i++) begin
        send_item(CMD_LOAD, ROW_AW'(i), make_row_bits(mode, i, rows), NODE_W'($urandom),
                  NODE_W'($urandom));
      end
      if ($urandom_range(4) == 0) begin
        send_item(CMD_LOAD, ROW_AW'($urandom), $urandom, NODE_W'($urandom),
                  NODE_W'($urandom));
      end

      queries = $urandom_range(12, 4);
      for (int q = 0; q < queries; q++) begin
        r = $urandom_range(99);
        if (rows > 0 && $urandom_range(99) < 85) begin
          src = NODE_W'($urandom_range(rows - 1));
          dst = NODE_W'($urandom_range(rows - 1));
        end else begin
          src = NODE_W'($urandom_range(63));
          dst = NODE_W'($urandom_range(63));
        end
        if (r < 35) begin
          send_item(CMD_CONN, ROW_AW'($urandom), $urandom, src, dst);
        end else if (r < 90) begin
          send_item(CMD_PATH, ROW_AW'($urandom), $urandom, src, dst);
        end else if (r < 95) begin
          send_item(CMD_NONE, ROW_AW'($urandom), $urandom, src, dst);
        end else begin
          send_item(CMD_LOAD, ROW_AW'($urandom),
                    make_row_bits(mode, $urandom_range(31), (rows > 0) ? rows : 1),
                    src, dst);
        end
      end
    end
  endtask

  // Main sequence
  initial begin : main_seq
    int wait_cycles;
    for (int i = 0; i < ROWS; i++) adj_model[i] = '0;
    node_count_model = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_after_reset();
    test_directed_cases();
    test_random_graphs(700, 0);
    test_random_graphs(650, 74);
    test_random_graphs(650, 31);

    // drain
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d loads, %0d connectivity, %0d path, %0d dropped",
             items_sent + dropped_count, load_count, conn_count, path_count, dropped_count);
    $display("%0d results checked over %0d node count writes, idle rates 0/74/31 percent",
             results_checked, cfg_writes);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/gre_pkg.sv
design/gre_ram.sv
design/gre_walk.sv
design/graph_reachability_engine.sv
design/gre_checker.sv
tb/graph_reachability_engine_test.sv
